// File: rtl/core/assert_macros.svh
// ----------------------------------------------------------------------------
// Assertion macros
// Shared concurrent assertion wrappers for the cache hit counter RTL.
// ----------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Checked outside reset only
`define CAHC_ASSERT(lbl, clk, rst, prop, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) prop) else $error(msg);

// Checked on every edge, reset included
`define CAHC_ASSERT_ALWAYS(lbl, clk, prop, msg) \
  lbl: assert property (@(posedge clk) prop) else $error(msg);

`endif

// File: rtl/core/cahc_pkg.sv
// ----------------------------------------------------------------------------
// cahc_pkg
// Types, sizes and helper functions for the cache hit counter.
// ----------------------------------------------------------------------------
package cahc_pkg;

  localparam int TOTAL_BLOCKS = 8;
  localparam int NUM_ORGS     = 4;
  localparam int STORE_DEPTH  = NUM_ORGS * TOTAL_BLOCKS;
  localparam int SET_BITS     = $clog2(TOTAL_BLOCKS);
  localparam int ADDR_WIDTH   = 8;
  localparam int COUNT_WIDTH  = 16;
  localparam int OUT_WIDTH    = 16;
  localparam int SCHEME_WIDTH = $clog2(NUM_ORGS);

  typedef logic [ADDR_WIDTH-1:0]   addr_t;
  typedef logic [COUNT_WIDTH-1:0]  count_t;
  typedef logic [OUT_WIDTH-1:0]    field_t;
  typedef logic [NUM_ORGS-1:0]     hit_vec_t;
  typedef logic [SCHEME_WIDTH-1:0] scheme_t;

  // Command from the pipeline to the cache bank
  typedef struct packed {
    logic  update;
    logic  clear;
    addr_t addr;
  } bank_cmd_t;

  function automatic count_t sat_inc(count_t v);
    count_t r;
    r = (v == {COUNT_WIDTH{1'b1}}) ? v : v + COUNT_WIDTH'(1);
    return r;
  endfunction

  // Clamp a count to the width of a result field
  function automatic field_t out_sat(count_t v);
    logic [COUNT_WIDTH+OUT_WIDTH-1:0] w;
    logic [COUNT_WIDTH+OUT_WIDTH-1:0] lim;
    field_t r;
    w   = {{OUT_WIDTH{1'b0}}, v};
    lim = {{COUNT_WIDTH{1'b0}}, {OUT_WIDTH{1'b1}}};
    r   = (w > lim) ? {OUT_WIDTH{1'b1}} : w[OUT_WIDTH-1:0];
    return r;
  endfunction

endpackage

// File: rtl/core/cahc_if.sv
// ----------------------------------------------------------------------------
// cahc_if
// Valid/ready channels for access transactions and result transactions.
// ----------------------------------------------------------------------------
interface cahc_access_if;
  logic              valid;
  logic              ready;
  cahc_pkg::addr_t   block_address;
  logic              last_access;

  modport source (output valid, output block_address, output last_access, input ready);
  modport sink   (input valid, input block_address, input last_access, output ready);
endinterface

interface cahc_result_if;
  logic              valid;
  logic              ready;
  logic              hit_one_way;
  logic              hit_two_way;
  logic              hit_four_way;
  logic              hit_eight_way;
  cahc_pkg::field_t  hits_one_way;
  cahc_pkg::field_t  hits_two_way;
  cahc_pkg::field_t  hits_four_way;
  cahc_pkg::field_t  hits_eight_way;
  cahc_pkg::field_t  access_total;
  cahc_pkg::scheme_t best_scheme;
  logic              run_done;

  modport source (
    output valid, input ready,
    output hit_one_way, output hit_two_way, output hit_four_way, output hit_eight_way,
    output hits_one_way, output hits_two_way, output hits_four_way, output hits_eight_way,
    output access_total, output best_scheme, output run_done
  );
  modport sink (
    input valid, output ready,
    input hit_one_way, input hit_two_way, input hit_four_way, input hit_eight_way,
    input hits_one_way, input hits_two_way, input hits_four_way, input hits_eight_way,
    input access_total, input best_scheme, input run_done
  );
endinterface

// File: rtl/core/cahc_cache_bank.sv
// ----------------------------------------------------------------------------
// cahc_cache_bank
// Tag store for the four cache organisations with parallel lookup and FIFO
// insertion on a miss.
// ----------------------------------------------------------------------------
module cahc_cache_bank (
  input  logic                clk,
  input  logic                rst,
  input  cahc_pkg::bank_cmd_t cmd,
  output cahc_pkg::hit_vec_t  hit
);

  cahc_pkg::addr_t                       store [cahc_pkg::STORE_DEPTH];
  logic [cahc_pkg::STORE_DEPTH-1:0]      valid;
  logic [cahc_pkg::STORE_DEPTH-1:0]      entry_hit;
  logic [cahc_pkg::STORE_DEPTH-1:0]      entry_sel;

  for (genvar g = 0; g < cahc_pkg::STORE_DEPTH; g++) begin : g_entry
    localparam int ORG  = g / cahc_pkg::TOTAL_BLOCKS;
    localparam int POS  = g % cahc_pkg::TOTAL_BLOCKS;
    localparam int WAYS = 1 << ORG;
    localparam int SETS = cahc_pkg::TOTAL_BLOCKS / WAYS;
    localparam int SET  = POS / WAYS;
    localparam int WAY  = POS % WAYS;

    logic [cahc_pkg::SET_BITS-1:0] addr_set;

    // set index is the address modulo the set count (a power of two)
    assign addr_set     = cmd.addr[cahc_pkg::SET_BITS-1:0] & cahc_pkg::SET_BITS'(SETS - 1);
    assign entry_sel[g] = (addr_set == cahc_pkg::SET_BITS'(SET));
    assign entry_hit[g] = entry_sel[g] && valid[g] && (store[g] == cmd.addr);

    if (WAY == 0) begin : g_front
      always_ff @(posedge clk) begin
        if (rst) begin
          valid[g] <= 1'b0;
        end else if (cmd.update) begin
          if (cmd.clear) begin
            valid[g] <= 1'b0;
          end else if (entry_sel[g] && !hit[ORG]) begin
            valid[g] <= 1'b1;
          end
        end
      end

      always_ff @(posedge clk) begin
        if (cmd.update && !cmd.clear && entry_sel[g] && !hit[ORG]) begin
          store[g] <= cmd.addr;
        end
      end
    end else begin : g_shift
      always_ff @(posedge clk) begin
        if (rst) begin
          valid[g] <= 1'b0;
        end else if (cmd.update) begin
          if (cmd.clear) begin
            valid[g] <= 1'b0;
          end else if (entry_sel[g] && !hit[ORG]) begin
            valid[g] <= valid[g-1];
          end
        end
      end

      always_ff @(posedge clk) begin
        if (cmd.update && !cmd.clear && entry_sel[g] && !hit[ORG]) begin
          store[g] <= store[g-1];
        end
      end
    end
  end

  for (genvar o = 0; o < cahc_pkg::NUM_ORGS; o++) begin : g_org
    assign hit[o] = |entry_hit[o*cahc_pkg::TOTAL_BLOCKS +: cahc_pkg::TOTAL_BLOCKS];
  end

endmodule

// File: rtl/core/cache_assoc_hit_counter.sv
// ----------------------------------------------------------------------------
// cache_assoc_hit_counter
// Runs every block address through a direct-mapped, 2-way, 4-way and fully
// associative 8-block cache with FIFO replacement and reports, per access,
// the four hit flags, saturating hit counts, the access count and the
// organisation with the most hits (fewer ways wins a tie). One access is
// taken per clock while the result is not stalled; the access is first held
// in the input register, then looked up, counted and placed in the result
// register in the same cycle, a stall of the result holding it in between.
// The lookup and FIFO shift of all 32 tag entries in that cycle set the
// rate. An access marked last closes the run and leaves all tags and
// counters cleared for the next access. Tags are invalid straight out of
// reset, so no clearing pass is needed.
// ----------------------------------------------------------------------------
`include "assert_macros.svh"

module cache_assoc_hit_counter (
  input  logic                  clk,
  input  logic                  rst,
  cahc_access_if.sink           access,
  cahc_result_if.source         result
);

  // input register
  logic                         s1_valid;
  cahc_pkg::addr_t              s1_addr;
  logic                         s1_last;

  logic                         out_valid;
  logic                         advance;
  logic                         proc;

  cahc_pkg::bank_cmd_t          cmd;
  cahc_pkg::hit_vec_t           hit;

  cahc_pkg::count_t             access_counter;
  cahc_pkg::count_t             access_counter_next;
  cahc_pkg::count_t             scheme_hits      [cahc_pkg::NUM_ORGS];
  cahc_pkg::count_t             scheme_hits_next [cahc_pkg::NUM_ORGS];
  cahc_pkg::scheme_t            best_next;
  cahc_pkg::count_t             best_val;

  // result register
  cahc_pkg::hit_vec_t           res_hit;
  cahc_pkg::field_t             res_hits [cahc_pkg::NUM_ORGS];
  cahc_pkg::field_t             res_total;
  cahc_pkg::scheme_t            res_best;
  logic                         res_done;

  assign advance      = !out_valid || result.ready;
  assign access.ready = !s1_valid || advance;
  assign proc         = s1_valid && advance;

  always_ff @(posedge clk) begin
    if (rst) begin
      s1_valid <= 1'b0;
    end else if (access.ready) begin
      s1_valid <= access.valid;
    end
  end

  always_ff @(posedge clk) begin
    if (access.valid && access.ready) begin
      s1_addr <= access.block_address;
      s1_last <= access.last_access;
    end
  end

  assign cmd.update = proc;
  assign cmd.clear  = s1_last;
  assign cmd.addr   = s1_addr;

  cahc_cache_bank u_bank (
    .clk (clk),
    .rst (rst),
    .cmd (cmd),
    .hit (hit)
  );

  always_comb begin
    access_counter_next = cahc_pkg::sat_inc(access_counter);
    for (int o = 0; o < cahc_pkg::NUM_ORGS; o++) begin
      scheme_hits_next[o] = hit[o] ? cahc_pkg::sat_inc(scheme_hits[o]) : scheme_hits[o];
    end
    // first maximum wins
    best_next = '0;
    best_val  = scheme_hits_next[0];
    for (int o = 1; o < cahc_pkg::NUM_ORGS; o++) begin
      if (scheme_hits_next[o] > best_val) begin
        best_next = cahc_pkg::SCHEME_WIDTH'(o);
        best_val  = scheme_hits_next[o];
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      access_counter <= '0;
      for (int o = 0; o < cahc_pkg::NUM_ORGS; o++) begin
        scheme_hits[o] <= '0;
      end
    end else if (proc) begin
      if (s1_last) begin
        access_counter <= '0;
        for (int o = 0; o < cahc_pkg::NUM_ORGS; o++) begin
          scheme_hits[o] <= '0;
        end
      end else begin
        access_counter <= access_counter_next;
        for (int o = 0; o < cahc_pkg::NUM_ORGS; o++) begin
          scheme_hits[o] <= scheme_hits_next[o];
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (advance) begin
      out_valid <= s1_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (proc) begin
      res_hit   <= hit;
      res_total <= cahc_pkg::out_sat(access_counter_next);
      res_best  <= best_next;
      res_done  <= s1_last;
      for (int o = 0; o < cahc_pkg::NUM_ORGS; o++) begin
        res_hits[o] <= cahc_pkg::out_sat(scheme_hits_next[o]);
      end
    end
  end

  assign result.valid          = out_valid;
  assign result.hit_one_way    = res_hit[0];
  assign result.hit_two_way    = res_hit[1];
  assign result.hit_four_way   = res_hit[2];
  assign result.hit_eight_way  = res_hit[3];
  assign result.hits_one_way   = res_hits[0];
  assign result.hits_two_way   = res_hits[1];
  assign result.hits_four_way  = res_hits[2];
  assign result.hits_eight_way = res_hits[3];
  assign result.access_total   = res_total;
  assign result.best_scheme    = res_best;
  assign result.run_done       = res_done;

  `CAHC_ASSERT_ALWAYS(a_reset_empties_output, clk, rst |=> !result.valid, "result valid after reset")
  `CAHC_ASSERT(a_stall_only_when_full, clk, rst, !access.ready |-> (s1_valid && out_valid && !result.ready), "access stalled without a full pipeline")
  `CAHC_ASSERT(a_run_end_clears, clk, rst, (proc && s1_last) |=> (access_counter == '0 && scheme_hits[3] == '0), "counters not cleared after last access")
  `CAHC_ASSERT(a_hits_bounded, clk, rst, result.valid |-> (result.hits_one_way <= result.access_total && result.hits_eight_way <= result.access_total), "hit count exceeds access count")

endmodule
